>>> hdl/first_fit_heap_allocator_defines.svh
// Assertion macros for the heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF

`define FFHA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FFHA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hdl/ffha_pkg.sv
package ffha_pkg;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [16:0] request_size;
        logic [15:0] block_addr;
    } t_req;

    typedef struct packed {
        logic [15:0] payload_addr;
        logic [2:0]  status;
        logic [16:0] used_bytes;
        logic [16:0] free_bytes;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_NULL     = 3'd1,
        ST_NOFIT    = 3'd2,
        ST_NOTBLOCK = 3'd3,
        ST_FREED    = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_UP_RD,
        S_UP_WR,
        S_SPLIT_NEW,
        S_SPLIT_CUR,
        S_NX_RD,
        S_NX_CHK,
        S_PV_RD,
        S_PV_CHK,
        S_MERGE,
        S_DN_RD,
        S_DN_WR,
        S_RESP
    } t_state;

endpackage

>>> hdl/ffha_ram.sv
module ffha_ram #(
    parameter int DW    = 38,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/first_fit_heap_allocator.sv
// Channel   Ports                  Handshake
// request   start, busy, i_req     taken when start is high and busy is low
// result    o_valid, o_rsp         one-cycle strobe, cannot be held off
//
// Block table sits in a single-port-write, registered-read RAM walked by a sequencer.
// Allocate: scans entries in order (read, check), and on a split moves each later entry up one slot (read, write).
// Free: scans entries the same way, reads the next and previous neighbors, then moves later entries down on merge.
// Only one request is in flight at a time.
// After reset, the S_INIT state writes the initial arena entry (busy high).
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 16,
    parameter int MAX_BLOCKS   = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ffha_pkg::t_req i_req,
    output logic          o_valid,
    output ffha_pkg::t_rsp o_rsp
);

    localparam int AW   = $clog2(HEAP_BYTES);
    localparam int SW   = AW + 1;
    localparam int WW   = ((SW > 17) ? SW : 17) + 1;
    localparam int IW   = $clog2(MAX_BLOCKS);
    localparam int CW   = $clog2(MAX_BLOCKS + 1);
    localparam int DW   = 1 + SW + AW;

    localparam logic [WW-1:0] HDR    = WW'(HEADER_BYTES);
    localparam logic [WW-1:0] HEAP_W = WW'(HEAP_BYTES);
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_BLOCKS);

    ffha_pkg::t_state r_state, n_state;
    logic             r_kind, n_kind;
    logic [WW-1:0]    r_need, n_need;
    logic [15:0]      r_addr, n_addr;
    logic [CW-1:0]    r_i, n_i;
    logic [CW-1:0]    r_k, n_k;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [1:0]       r_amt, n_amt;
    logic [WW-1:0]    r_used, n_used;
    logic [WW-1:0]    r_free, n_free;
    logic [AW-1:0]    r_cstart, n_cstart;
    logic [WW-1:0]    r_csize, n_csize;
    logic [WW-1:0]    r_s, n_s;
    logic [AW-1:0]    r_pstart, n_pstart;
    logic [WW-1:0]    r_psize, n_psize;
    logic             r_nfree, n_nfree;
    logic             r_pfree, n_pfree;
    logic [2:0]       r_status, n_status;
    logic [WW-1:0]    r_paddr, n_paddr;
    logic             r_valid, n_valid;
    ffha_pkg::t_rsp   r_rsp, n_rsp;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic [AW-1:0] e_start;
    logic [WW-1:0] e_size;
    logic          e_used;
    logic [WW-1:0] e_pay;
    logic [CW:0]   k_plus;

    assign e_start = ram_rdata[AW-1:0];
    assign e_size  = WW'(ram_rdata[AW+SW-1:AW]);
    assign e_used  = ram_rdata[DW-1];
    assign e_pay   = WW'(e_start) + HDR;

    ffha_ram #(.DW(DW), .DEPTH(MAX_BLOCKS), .AW(IW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::S_INIT;
            r_cnt   <= CW'(1);
            r_used  <= HDR;
            r_free  <= HEAP_W - HDR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_used  <= n_used;
            r_free  <= n_free;
            r_valid <= n_valid;
        end
        r_kind   <= n_kind;
        r_need   <= n_need;
        r_addr   <= n_addr;
        r_i      <= n_i;
        r_k      <= n_k;
        r_amt    <= n_amt;
        r_cstart <= n_cstart;
        r_csize  <= n_csize;
        r_s      <= n_s;
        r_pstart <= n_pstart;
        r_psize  <= n_psize;
        r_nfree  <= n_nfree;
        r_pfree  <= n_pfree;
        r_status <= n_status;
        r_paddr  <= n_paddr;
        r_rsp    <= n_rsp;
    end

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_need   = r_need;
        n_addr   = r_addr;
        n_i      = r_i;
        n_k      = r_k;
        n_cnt    = r_cnt;
        n_amt    = r_amt;
        n_used   = r_used;
        n_free   = r_free;
        n_cstart = r_cstart;
        n_csize  = r_csize;
        n_s      = r_s;
        n_pstart = r_pstart;
        n_psize  = r_psize;
        n_nfree  = r_nfree;
        n_pfree  = r_pfree;
        n_status = r_status;
        n_paddr  = r_paddr;
        n_valid  = 1'b0;
        n_rsp    = r_rsp;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        k_plus    = '0;

        unique case (r_state)
            ffha_pkg::S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = {1'b0, SW'(HEAP_W - HDR), AW'(0)};
                n_state   = ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_IDLE: begin
                if (start) begin
                    n_kind  = i_req.kind;
                    n_addr  = i_req.block_addr;
                    n_need  = (WW'(i_req.request_size) + WW'(3)) & ~WW'(3);
                    n_i     = '0;
                    n_paddr = '0;
                    n_state = ffha_pkg::S_SCAN_RD;
                    if (i_req.kind == ffha_pkg::KIND_ALLOC) begin
                        if (i_req.request_size == '0) begin
                            n_status = ffha_pkg::ST_NULL;
                            n_state  = ffha_pkg::S_RESP;
                        end
                    end else if (i_req.block_addr == '0) begin
                        n_status = ffha_pkg::ST_NULL;
                        n_state  = ffha_pkg::S_RESP;
                    end
                end
            end
            ffha_pkg::S_SCAN_RD: begin
                ram_raddr = r_i[IW-1:0];
                if (r_i == r_cnt) begin
                    n_status = (r_kind == ffha_pkg::KIND_ALLOC) ? ffha_pkg::ST_NOFIT
                                                                : ffha_pkg::ST_NOTBLOCK;
                    n_state  = ffha_pkg::S_RESP;
                end else begin
                    n_state = ffha_pkg::S_SCAN_CHK;
                end
            end
            ffha_pkg::S_SCAN_CHK: begin
                n_cstart = e_start;
                n_csize  = e_size;
                n_i      = r_i + CW'(1);
                n_state  = ffha_pkg::S_SCAN_RD;
                if (r_kind == ffha_pkg::KIND_ALLOC) begin
                    if (!e_used && e_size >= r_need) begin
                        n_i      = r_i;
                        n_paddr  = e_pay;
                        n_status = ffha_pkg::ST_DONE;
                        if (e_size > r_need + HDR + WW'(4) && r_cnt < MAX_C) begin
                            n_used  = r_used + r_need;
                            n_free  = r_free - r_need;
                            n_k     = r_cnt;
                            n_state = ffha_pkg::S_UP_RD;
                        end else begin
                            n_used    = r_used + e_size;
                            n_free    = r_free - e_size;
                            ram_we    = 1'b1;
                            ram_waddr = r_i[IW-1:0];
                            ram_wdata = {1'b1, SW'(e_size), e_start};
                            n_state   = ffha_pkg::S_RESP;
                        end
                    end
                end else if (e_pay[15:0] == r_addr) begin
                    n_i = r_i;
                    if (!e_used) begin
                        n_status = ffha_pkg::ST_FREED;
                        n_state  = ffha_pkg::S_RESP;
                    end else begin
                        n_status = ffha_pkg::ST_DONE;
                        n_used   = r_used - e_size;
                        n_free   = r_free + e_size;
                        n_state  = ffha_pkg::S_NX_RD;
                    end
                end
            end
            // open a hole at i+1 by moving the tail up one entry
            ffha_pkg::S_UP_RD: begin
                ram_raddr = IW'(r_k - CW'(1));
                if ({1'b0, r_k} > ({1'b0, r_i} + (CW+1)'(1))) begin
                    n_state = ffha_pkg::S_UP_WR;
                end else begin
                    n_state = ffha_pkg::S_SPLIT_NEW;
                end
            end
            ffha_pkg::S_UP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_k[IW-1:0];
                ram_wdata = ram_rdata;
                n_k       = r_k - CW'(1);
                n_state   = ffha_pkg::S_UP_RD;
            end
            ffha_pkg::S_SPLIT_NEW: begin
                ram_we    = 1'b1;
                ram_waddr = IW'(r_i + CW'(1));
                ram_wdata = {1'b0, SW'(r_csize - r_need - HDR),
                             AW'(WW'(r_cstart) + HDR + r_need)};
                n_state   = ffha_pkg::S_SPLIT_CUR;
            end
            ffha_pkg::S_SPLIT_CUR: begin
                ram_we    = 1'b1;
                ram_waddr = r_i[IW-1:0];
                ram_wdata = {1'b1, SW'(r_need), r_cstart};
                n_cnt     = r_cnt + CW'(1);
                n_state   = ffha_pkg::S_RESP;
            end
            ffha_pkg::S_NX_RD: begin
                ram_raddr = IW'(r_i + CW'(1));
                n_s       = r_csize;
                n_nfree   = 1'b0;
                if (({1'b0, r_i} + (CW+1)'(1)) < {1'b0, r_cnt}) begin
                    n_state = ffha_pkg::S_NX_CHK;
                end else begin
                    n_state = ffha_pkg::S_PV_RD;
                end
            end
            ffha_pkg::S_NX_CHK: begin
                n_nfree = !e_used;
                if (!e_used) begin
                    n_s = r_csize + e_size + HDR;
                end
                n_state = ffha_pkg::S_PV_RD;
            end
            ffha_pkg::S_PV_RD: begin
                ram_raddr = IW'(r_i - CW'(1));
                n_pfree   = 1'b0;
                if (r_i != '0) begin
                    n_state = ffha_pkg::S_PV_CHK;
                end else begin
                    n_state = ffha_pkg::S_MERGE;
                end
            end
            ffha_pkg::S_PV_CHK: begin
                n_pfree  = !e_used;
                n_pstart = e_start;
                n_psize  = e_size;
                n_state  = ffha_pkg::S_MERGE;
            end
            ffha_pkg::S_MERGE: begin
                ram_we = 1'b1;
                if (r_pfree) begin
                    ram_waddr = IW'(r_i - CW'(1));
                    ram_wdata = {1'b0, SW'(r_psize + r_s + HDR), r_pstart};
                    n_k       = r_i;
                    n_amt     = r_nfree ? 2'd2 : 2'd1;
                end else begin
                    ram_waddr = r_i[IW-1:0];
                    ram_wdata = {1'b0, SW'(r_s), r_cstart};
                    n_k       = r_i + CW'(1);
                    n_amt     = r_nfree ? 2'd1 : 2'd0;
                end
                n_state = ffha_pkg::S_DN_RD;
            end
            // close the gap by moving the tail down r_amt entries
            ffha_pkg::S_DN_RD: begin
                k_plus    = {1'b0, r_k} + (CW+1)'(r_amt);
                ram_raddr = k_plus[IW-1:0];
                if (k_plus < {1'b0, r_cnt}) begin
                    n_state = ffha_pkg::S_DN_WR;
                end else begin
                    n_cnt   = r_cnt - CW'(r_amt);
                    n_state = ffha_pkg::S_RESP;
                end
            end
            ffha_pkg::S_DN_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_k[IW-1:0];
                ram_wdata = ram_rdata;
                n_k       = r_k + CW'(1);
                n_state   = ffha_pkg::S_DN_RD;
            end
            ffha_pkg::S_RESP: begin
                n_valid            = 1'b1;
                n_rsp.payload_addr = r_paddr[15:0];
                n_rsp.status       = r_status;
                n_rsp.used_bytes   = r_used[16:0];
                n_rsp.free_bytes   = r_free[16:0];
                n_state            = ffha_pkg::S_IDLE;
            end
            default: begin
                n_state = ffha_pkg::S_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != ffha_pkg::S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    `FFHA_ASSERT_SAME(a_cnt_range, i_clk, i_rst_n, !busy,
        (r_cnt != '0) && (r_cnt <= MAX_C), "block count out of range")
    `FFHA_ASSERT_SAME(a_accounting, i_clk, i_rst_n, !busy,
        (r_used + r_free) == HEAP_W, "used plus free differs from arena size")
    `FFHA_ASSERT_NEXT(a_one_pulse, i_clk, i_rst_n, o_valid, !o_valid,
        "result strobe longer than one cycle")
    `FFHA_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, start && !busy, busy,
        "request taken but sequencer not busy")

endmodule

>>> tb/sv/ffha_checker.sv
`timescale 1ns / 1ps

module ffha_checker #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 16,
    parameter int MAX_BLOCKS   = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  ffha_pkg::t_req i_req,
    input  logic           i_valid,
    input  ffha_pkg::t_rsp i_rsp,
    output int             o_errors,
    output int             o_pending
);

    int unsigned    blk_start [MAX_BLOCKS];
    int unsigned    blk_size  [MAX_BLOCKS];
    bit             blk_used  [MAX_BLOCKS];
    int unsigned    blk_count;
    int unsigned    used_ctr;
    int unsigned    free_ctr;
    ffha_pkg::t_rsp rsp_fifo[$];

    function automatic void heap_reset();
        blk_count = 1;
        blk_start[0] = 0;
        blk_size[0] = HEAP_BYTES - HEADER_BYTES;
        blk_used[0] = 0;
        used_ctr = HEADER_BYTES;
        free_ctr = HEAP_BYTES - HEADER_BYTES;
    endfunction

    function automatic void remove_at(int unsigned at);
        for (int unsigned k = at; k + 1 < blk_count; k++) begin
            blk_start[k] = blk_start[k+1];
            blk_size[k]  = blk_size[k+1];
            blk_used[k]  = blk_used[k+1];
        end
        blk_count--;
    endfunction

    function automatic ffha_pkg::t_rsp heap_apply(ffha_pkg::t_req r);
        ffha_pkg::t_rsp    o;
        int unsigned       need;
        int unsigned       i;
        ffha_pkg::t_status st;
        o = '0;
        if (r.kind == ffha_pkg::KIND_ALLOC) begin
            st = ffha_pkg::ST_NOFIT;
            need = (int'(r.request_size) + 3) & ~3;
            if (r.request_size == 0) st = ffha_pkg::ST_NULL;
            else begin
                for (i = 0; i < blk_count; i++) begin
                    if (!blk_used[i] && blk_size[i] >= need) begin
                        if (blk_size[i] > need + HEADER_BYTES + 4 && blk_count < MAX_BLOCKS) begin
                            for (int unsigned k = blk_count; k > i + 1; k--) begin
                                blk_start[k] = blk_start[k-1];
                                blk_size[k]  = blk_size[k-1];
                                blk_used[k]  = blk_used[k-1];
                            end
                            blk_start[i+1] = blk_start[i] + HEADER_BYTES + need;
                            blk_size[i+1]  = blk_size[i] - need - HEADER_BYTES;
                            blk_used[i+1]  = 0;
                            blk_count++;
                            blk_size[i] = need;
                        end
                        blk_used[i] = 1;
                        used_ctr += blk_size[i];
                        free_ctr -= blk_size[i];
                        o.payload_addr = 16'(blk_start[i] + HEADER_BYTES);
                        st = ffha_pkg::ST_DONE;
                        break;
                    end
                end
            end
        end else if (r.block_addr == 0) begin
            st = ffha_pkg::ST_NULL;
        end else begin
            for (i = 0; i < blk_count; i++)
                if (16'(blk_start[i] + HEADER_BYTES) == r.block_addr) break;
            if (i >= blk_count) st = ffha_pkg::ST_NOTBLOCK;
            else if (!blk_used[i]) st = ffha_pkg::ST_FREED;
            else begin
                st = ffha_pkg::ST_DONE;
                blk_used[i] = 0;
                used_ctr -= blk_size[i];
                free_ctr += blk_size[i];
                if (i + 1 < blk_count && !blk_used[i+1]) begin
                    blk_size[i] += blk_size[i+1] + HEADER_BYTES;
                    remove_at(i + 1);
                end
                if (i > 0 && !blk_used[i-1]) begin
                    blk_size[i-1] += blk_size[i] + HEADER_BYTES;
                    remove_at(i);
                end
            end
        end
        o.status = st;
        o.used_bytes = 17'(used_ctr);
        o.free_bytes = 17'(free_ctr);
        return o;
    endfunction

    assign o_pending = rsp_fifo.size();

    always @(posedge i_clk) begin
        ffha_pkg::t_rsp want;
        if (!i_rst_n) begin
            heap_reset();
            rsp_fifo.delete();
            o_errors <= 0;
        end else begin
            if (i_valid) begin
                if (rsp_fifo.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_rsp);
                    o_errors <= o_errors + 1;
                end else begin
                    want = rsp_fifo.pop_front();
                    if (want.payload_addr != i_rsp.payload_addr
                        || want.status != i_rsp.status
                        || want.used_bytes != i_rsp.used_bytes
                        || want.free_bytes != i_rsp.free_bytes) begin
                        $display("%0t: mismatch expected addr=%h st=%0d used=%0d free=%0d",
                                 $time, want.payload_addr, want.status,
                                 want.used_bytes, want.free_bytes);
                        $display("%0t:          actual   addr=%h st=%0d used=%0d free=%0d",
                                 $time, i_rsp.payload_addr, i_rsp.status,
                                 i_rsp.used_bytes, i_rsp.free_bytes);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            // request taken this edge; its result cannot appear in the same cycle
            if (i_start && !i_busy) rsp_fifo.push_back(heap_apply(i_req));
        end
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int HEADER_BYTES = 16;
    localparam int CYCLE_LIMIT  = 1_500_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    ffha_pkg::t_req i_req = '0;
    logic o_valid;
    ffha_pkg::t_rsp o_rsp;
    int   errors;
    int   pending;
    int   cycles = 0;
    logic [15:0] live[$];

    always #2 i_clk = ~i_clk;

    first_fit_heap_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_valid(o_valid), .o_rsp(o_rsp)
    );

    ffha_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_req(i_req), .i_valid(o_valid), .i_rsp(o_rsp),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // track payload offsets handed out, to free real blocks
    always @(posedge i_clk)
        if (i_rst_n && o_valid && o_rsp.status == ffha_pkg::ST_DONE && o_rsp.payload_addr != 0)
            live.push_back(o_rsp.payload_addr);

    // start stays high after the accept; whoever idles next drops it
    task automatic send(logic kind, logic [16:0] sz, logic [15:0] addr);
        start <= 1'b1;
        i_req <= '{kind: kind, request_size: sz, block_addr: addr};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_alloc(logic [16:0] sz);
        send(ffha_pkg::KIND_ALLOC, sz, 16'($urandom));
    endtask

    task automatic send_free(logic [15:0] addr);
        send(ffha_pkg::KIND_FREE, 17'($urandom), addr);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic free_live_random();
        int idx;
        drain();
        if (live.size() == 0) send_free(16'(HEADER_BYTES));
        else begin
            idx = $urandom_range(live.size() - 1);
            send_free(live[idx]);
            live.delete(idx);
        end
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)      send_alloc(17'($urandom_range(1, 600)));
        else if (pick < 50) send_alloc(17'($urandom_range(0, 65536)));
        else if (pick < 85) free_live_random();
        else if (pick < 90) send_free(16'($urandom));
        else if (pick < 95) send_free(16'($urandom_range(1, 64) * 4));
        else if (live.size() != 0) send_free(live[$urandom_range(live.size() - 1)]);
        else send_free(16'h0);
    endtask

    initial begin
        int burst;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_alloc(17'd0);
        send_free(16'h0);
        send_alloc(17'd65536);
        send_alloc(17'd1);
        send_alloc(17'd5);
        send_alloc(17'd20);
        drain();
        send_free(16'hFFFF);
        send_free(16'd17);
        send_free(live[1]);
        send_free(live[1]);
        send_free(live[0]);
        send_free(live[2]);
        drain();
        live.delete();
        send_alloc(17'd65520);
        send_alloc(17'd4);
        send_free(16'(HEADER_BYTES));
        send_alloc(17'h1FFFF);
        // fill the table until it is full so whole blocks get handed out
        repeat (70) send_alloc(17'd8);
        send_alloc(17'd65000);
        drain();
        while (live.size() != 0) begin
            send_free(live.pop_front());
            drain();
        end
        send_alloc(17'd65520);
        send_alloc(17'd65521);
        drain();
        while (live.size() != 0) send_free(live.pop_front());

        for (int n = 0; n < 1000; ) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && n < 1000; b++, n++) random_item();
            if ($urandom_range(3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            if (n > 600 && n < 620) drain();
        end

        drain();
        repeat (300) @(posedge i_clk);
        if (errors == 0 && pending == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
